FILE: src/afld_pkg.sv
package afld_pkg;

   // Configuration register indexes
   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_THRESHOLD_LEVEL = 2'd0;
   localparam csr_index_type CSR_SMOOTHING_GAIN  = 2'd1;

   localparam int CSR_DATA_W   = 17;
   localparam int THRESHOLD_W  = 16;
   localparam int GAIN_W       = 17;
   localparam int GAIN_FRAC    = 16;
   localparam int LEVEL_OUT_W  = 16;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd328;
   localparam logic [GAIN_W-1:0]      GAIN_RESET      = 17'd6554;
   localparam logic [GAIN_W-1:0]      GAIN_ONE        = 17'h10000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_DIFF,
      ST_MUL,
      ST_STEP,
      ST_UPD,
      ST_CMP
   } state_type;

   typedef struct packed {
      logic valid;
      logic muted;
   } start_type;

   typedef struct packed {
      logic                   valid;
      logic                   is_loud;
      logic                   loud_changed;
      logic [LEVEL_OUT_W-1:0] level;
   } result_type;

endpackage

FILE: src/afld_core.sv
module afld_core #(
   parameter int SAMPLE_BITS         = 16,
   parameter int LEVEL_FRACTION_BITS = 8,
   parameter int FRAME_MAX           = 4096,
   localparam int CNT_W = $clog2(FRAME_MAX + 1),
   localparam int SUM_W = SAMPLE_BITS + CNT_W
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  afld_pkg::start_type                    start,
   input  logic [SUM_W-1:0]                       start_sum,
   input  logic [CNT_W-1:0]                       start_count,
   input  logic [afld_pkg::THRESHOLD_W-1:0]       threshold,
   input  logic [afld_pkg::GAIN_W-1:0]            gain,
   input  logic                                   slot_free,
   output logic                                   idle,
   output afld_pkg::result_type                   result
);

   localparam int LFB      = LEVEL_FRACTION_BITS;
   localparam int DIV_W    = SUM_W + LFB;
   localparam int LEV_W    = SAMPLE_BITS + LFB;
   localparam int GW       = afld_pkg::GAIN_W;
   localparam int PROD_W   = LEV_W + GW;
   localparam int REM_W    = CNT_W + 1;
   localparam int AW       = (PROD_W > REM_W) ? PROD_W : REM_W;
   localparam int ITER_MAX = (DIV_W > GW) ? DIV_W : GW;
   localparam int ITER_W   = $clog2(ITER_MAX + 1);
   localparam int THR_SH_W = afld_pkg::THRESHOLD_W + LFB;
   localparam int CMP_W    = (LEV_W > THR_SH_W) ? LEV_W : THR_SH_W;
   localparam int OUT_W    = afld_pkg::LEVEL_OUT_W;

   afld_pkg::state_type state_ff, state_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              mute_ff, mute_in;
   logic              neg_ff, neg_in;
   logic [LEV_W-1:0]  diff_ff, diff_in;
   logic [GW-1:0]     gsr_ff, gsr_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [LEV_W-1:0]  level_ff, level_in;
   logic              flag_ff, flag_in;

   // shared add/subtract unit
   logic [AW-1:0] add_x, add_y;
   logic          add_sub;
   logic [AW:0]   add_out;
   logic [REM_W-1:0] rem_shift;

   logic [LEV_W-1:0]   mean;
   logic [LEV_W:0]     step;
   logic               flag_new;
   logic [SAMPLE_BITS+OUT_W-1:0] level_wide;

   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign mean      = quo_ff[LEV_W-1:0];
   assign step      = acc_ff[PROD_W-1:afld_pkg::GAIN_FRAC];
   assign flag_new  = (CMP_W'(level_ff) > (CMP_W'(threshold) << LFB));
   assign level_wide = {{OUT_W{1'b0}}, level_ff[LEV_W-1:LFB]};

   always_comb begin
      if (state_ff == afld_pkg::ST_DIV) begin
         add_x   = AW'(rem_shift);
         add_y   = AW'(dvs_ff);
         add_sub = 1'b1;
      end else begin
         add_x   = AW'({acc_ff[PROD_W-2:0], 1'b0});
         add_y   = gsr_ff[GW-1] ? AW'(diff_ff) : '0;
         add_sub = 1'b0;
      end
      add_out = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (AW+1)'(add_sub);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= afld_pkg::ST_IDLE;
         level_ff <= '0;
         flag_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         level_ff <= level_in;
         flag_ff  <= flag_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      iter_ff <= iter_in;
      mute_ff <= mute_in;
      neg_ff  <= neg_in;
      diff_ff <= diff_in;
      gsr_ff  <= gsr_in;
      acc_ff  <= acc_in;
   end

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      iter_in  = iter_ff;
      mute_in  = mute_ff;
      neg_in   = neg_ff;
      diff_in  = diff_ff;
      gsr_in   = gsr_ff;
      acc_in   = acc_ff;
      level_in = level_ff;
      flag_in  = flag_ff;
      result   = '0;

      unique case (state_ff)
         afld_pkg::ST_IDLE: begin
            if (start.valid) begin
               quo_in  = DIV_W'(start_sum) << LFB;
               dvs_in  = start_count;
               rem_in  = '0;
               iter_in = ITER_W'(DIV_W);
               mute_in = start.muted;
               state_in = start.muted ? afld_pkg::ST_UPD : afld_pkg::ST_DIV;
            end
         end
         afld_pkg::ST_DIV: begin
            // one quotient bit per cycle, restoring
            rem_in  = add_out[AW] ? add_out[CNT_W-1:0] : rem_shift[CNT_W-1:0];
            quo_in  = {quo_ff[DIV_W-2:0], add_out[AW]};
            iter_in = iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               state_in = afld_pkg::ST_DIFF;
            end
         end
         afld_pkg::ST_DIFF: begin
            neg_in  = (mean < level_ff);
            diff_in = (mean < level_ff) ? (level_ff - mean) : (mean - level_ff);
            gsr_in  = (gain > afld_pkg::GAIN_ONE) ? afld_pkg::GAIN_ONE : gain;
            acc_in  = '0;
            iter_in = ITER_W'(GW);
            state_in = afld_pkg::ST_MUL;
         end
         afld_pkg::ST_MUL: begin
            // one gain bit per cycle, MSB first
            acc_in  = add_out[PROD_W-1:0];
            gsr_in  = {gsr_ff[GW-2:0], 1'b0};
            iter_in = iter_ff - 1'b1;
            if (iter_ff == ITER_W'(1)) begin
               state_in = afld_pkg::ST_STEP;
            end
         end
         afld_pkg::ST_STEP: begin
            // round the magnitude up so a falling step floors
            if (neg_ff) begin
               acc_in = acc_ff + PROD_W'(afld_pkg::GAIN_ONE - 1'b1);
            end
            state_in = afld_pkg::ST_UPD;
         end
         afld_pkg::ST_UPD: begin
            if (mute_ff) begin
               level_in = '0;
            end else if (!neg_ff) begin
               level_in = level_ff + step[LEV_W-1:0];
            end else if (step > {1'b0, level_ff}) begin
               level_in = '0;
            end else begin
               level_in = level_ff - step[LEV_W-1:0];
            end
            state_in = afld_pkg::ST_CMP;
         end
         afld_pkg::ST_CMP: begin
            if (slot_free) begin
               result.valid        = 1'b1;
               result.is_loud      = flag_new;
               result.loud_changed = flag_new ^ flag_ff;
               result.level        = level_wide[OUT_W-1:0];
               flag_in  = flag_new;
               state_in = afld_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = afld_pkg::ST_IDLE;
         end
      endcase
   end

   assign idle = (state_ff == afld_pkg::ST_IDLE);

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start.valid |-> state_ff == afld_pkg::ST_IDLE)
      else $error("frame started while the unit is busy");
   a_result_slot: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> slot_free)
      else $error("result issued into an occupied output slot");
   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != afld_pkg::ST_UPD) |=> $stable(level_ff))
      else $error("level changed outside the update step");
   a_flag_follow: assert property (@(posedge clock) disable iff (reset)
      result.valid |=> (state_ff == afld_pkg::ST_IDLE) && (flag_ff == $past(result.is_loud)))
      else $error("loud flag not taken over from the issued result");
`endif

endmodule

FILE: src/audio_frame_level_detector.sv
// Channel  Handshake            Fields                                     Moves
// req      req_valid/req_ready  sample_value, last_in_frame, frame_muted   one sample word in
// rsp      rsp_valid/rsp_ready  is_loud, loud_changed, level               one report word out
// csr      csr_valid/csr_ready  csr_index, csr_data                        one register write in
//
// A sample word that does not end its frame is taken whenever the core is idle.
// A frame-end word holds req_ready low through SAMPLE_BITS + clog2(FRAME_MAX+1) +
// LEVEL_FRACTION_BITS divide steps on the shared adder, a difference state, 17
// multiply steps and the step, update and compare states; a muted one skips to update.
// Reset is synchronous and active high; it clears the level, the loud flag, the
// running sum and count, and restores the register defaults.
// A stalled result holds in the output register; the next frame may accumulate
// meanwhile, and a frame end waits in the final step for the slot.
module audio_frame_level_detector #(
   parameter int FRAME_MAX           = 4096,
   parameter int SAMPLE_BITS         = 16,
   parameter int LEVEL_FRACTION_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_sample_value,
   input  logic                                  req_last_in_frame,
   input  logic                                  req_frame_muted,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_is_loud,
   output logic                                  rsp_loud_changed,
   output logic [afld_pkg::LEVEL_OUT_W-1:0]      rsp_level,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  afld_pkg::csr_index_type               csr_index,
   input  logic [afld_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int CNT_W = $clog2(FRAME_MAX + 1);
   localparam int SUM_W = SAMPLE_BITS + CNT_W;

   // configuration registers
   logic [afld_pkg::THRESHOLD_W-1:0] thr_ff, thr_in;
   logic [afld_pkg::GAIN_W-1:0]      gain_ff, gain_in;

   // frame accumulation
   logic [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic [CNT_W-1:0] cnt_ff, cnt_in, cnt_add;
   logic [SAMPLE_BITS-1:0] mag;
   logic room;
   logic accept;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             loud_ff, loud_in;
   logic                             chg_ff, chg_in;
   logic [afld_pkg::LEVEL_OUT_W-1:0] lvl_ff, lvl_in;
   logic                             slot_free;

   afld_pkg::start_type  start;
   afld_pkg::result_type result;
   logic                 core_idle;

   // take register writes at any time; software writes only while idle
   assign csr_ready = 1'b1;

   always_comb begin
      thr_in  = thr_ff;
      gain_in = gain_ff;
      if (csr_valid) begin
         unique case (csr_index)
            afld_pkg::CSR_THRESHOLD_LEVEL: thr_in  = csr_data[afld_pkg::THRESHOLD_W-1:0];
            afld_pkg::CSR_SMOOTHING_GAIN:  gain_in = csr_data[afld_pkg::GAIN_W-1:0];
            default: begin
               // drop writes to unmapped indexes
               thr_in = thr_ff;
            end
         endcase
      end
   end

   // accept a sample word only while the arithmetic unit is free
   assign req_ready = core_idle;
   assign accept    = req_valid & req_ready;

   // magnitude; the most negative sample maps to 2^(SAMPLE_BITS-1)
   assign mag = req_sample_value[SAMPLE_BITS-1]
                ? ($unsigned(~req_sample_value) + 1'b1)
                : $unsigned(req_sample_value);

   // saturate count and sum once the frame reaches FRAME_MAX
   assign room    = (cnt_ff < CNT_W'(FRAME_MAX));
   assign sum_add = room ? (sum_ff + SUM_W'(mag)) : sum_ff;
   assign cnt_add = room ? (cnt_ff + 1'b1) : cnt_ff;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_last_in_frame) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_add;
            cnt_in = cnt_add;
         end
      end
      start.valid = accept & req_last_in_frame;
      start.muted = req_frame_muted;
   end

   // advance the output register when it is empty or being taken
   assign slot_free = !rsp_valid_ff | rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      loud_in      = loud_ff;
      chg_in       = chg_ff;
      lvl_in       = lvl_ff;
      if (result.valid) begin
         rsp_valid_in = 1'b1;
         loud_in      = result.is_loud;
         chg_in       = result.loud_changed;
         lvl_in       = result.level;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= afld_pkg::THRESHOLD_RESET;
         gain_ff      <= afld_pkg::GAIN_RESET;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thr_ff       <= thr_in;
         gain_ff      <= gain_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      loud_ff <= loud_in;
      chg_ff  <= chg_in;
      lvl_ff  <= lvl_in;
   end

   afld_core #(
      .SAMPLE_BITS        (SAMPLE_BITS),
      .LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS),
      .FRAME_MAX          (FRAME_MAX)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_sum  (sum_add),
      .start_count(cnt_add),
      .threshold  (thr_ff),
      .gain       (gain_ff),
      .slot_free  (slot_free),
      .idle       (core_idle),
      .result     (result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_loud      = loud_ff;
   assign rsp_loud_changed = chg_ff;
   assign rsp_level        = lvl_ff;

endmodule

FILE: tb/tb_audio_frame_level_detector.sv
`timescale 1ns / 1ps

// Sample words go in on req_*, one level report word per frame end comes out
// on rsp_*. A predictor tracks the running sum, count, smoothed level and loud
// flag, and queues one expected report per frame end; the checker pops it as
// each report word is taken.
module tb_audio_frame_level_detector;

   localparam int FRAME_MAX      = 4096;
   localparam int LEVEL_FRAC     = 8;
   localparam int RANDOM_SAMPLES = 1550;
   // Extra idle wait after the last expected report word has been taken.
   localparam int SETTLE_CYCLES  = 80;
   // Indexes with no register behind them; writes there must change nothing.
   localparam afld_pkg::csr_index_type CSR_UNMAPPED_2 = 2'd2;
   localparam afld_pkg::csr_index_type CSR_UNMAPPED_3 = 2'd3;

   typedef struct packed {
      logic                             is_loud;
      logic                             loud_changed;
      logic [afld_pkg::LEVEL_OUT_W-1:0] level;
   } level_report_type;

   logic                             clock;
   logic                             reset;
   logic                             req_valid;
   logic                             req_ready;
   logic signed [15:0]               req_sample_value;
   logic                             req_last_in_frame;
   logic                             req_frame_muted;
   logic                             rsp_valid;
   logic                             rsp_ready;
   logic                             rsp_is_loud;
   logic                             rsp_loud_changed;
   logic [afld_pkg::LEVEL_OUT_W-1:0] rsp_level;
   logic                             csr_valid;
   logic                             csr_ready;
   afld_pkg::csr_index_type          csr_index;
   logic [afld_pkg::CSR_DATA_W-1:0]  csr_data;

   // Predicted block state and register copies.
   logic [afld_pkg::THRESHOLD_W-1:0] model_threshold;
   logic [afld_pkg::GAIN_W-1:0]      model_gain;
   longint unsigned                  model_sum;
   longint unsigned                  model_count;
   longint unsigned                  model_level;
   logic                             model_loud;

   level_report_type        expected_reports[$];
   int unsigned             mismatch_count;
   int unsigned             result_pause;
   int unsigned             rsp_hold_cycles;
   bit                      sample_gaps_on;
   bit                      result_stalls_on;

   audio_frame_level_detector dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_value  (req_sample_value),
      .req_last_in_frame (req_last_in_frame),
      .req_frame_muted   (req_frame_muted),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_is_loud       (rsp_is_loud),
      .rsp_loud_changed  (rsp_loud_changed),
      .rsp_level         (rsp_level),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin : watchdog
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Account one accepted sample word; on a frame end queue the level report.
   function automatic void predict_frame_level(logic signed [15:0] value, logic last,
                                                logic muted);
      logic [15:0]      mag16;
      longint unsigned  mean;
      longint unsigned  gain;
      longint unsigned  step;
      longint unsigned  loud_limit;
      longint unsigned  level_int;
      logic             prior_loud;
      level_report_type report;
      // Two's complement magnitude; the most negative word gives 32768.
      mag16 = value;
      if (value[15])
         mag16 = ~mag16 + 16'd1;
      // Drop words past FRAME_MAX: sum and count saturate.
      if (model_count < FRAME_MAX) begin
         model_sum   += mag16;
         model_count += 1;
      end
      if (!last)
         return;
      if (muted) begin
         model_level = 0;
      end else begin
         mean = (model_count != 0) ? (model_sum << LEVEL_FRAC) / model_count : 0;
         gain = (model_gain > afld_pkg::GAIN_ONE) ? afld_pkg::GAIN_ONE : model_gain;
         if (mean >= model_level) begin
            model_level += ((mean - model_level) * gain) >> afld_pkg::GAIN_FRAC;
         end else begin
            // Floor of a negative step: round the magnitude up.
            step = ((model_level - mean) * gain + 64'd65535) >> afld_pkg::GAIN_FRAC;
            if (step > model_level)
               step = model_level;
            model_level -= step;
         end
      end
      model_sum   = 0;
      model_count = 0;
      prior_loud  = model_loud;
      loud_limit  = model_threshold;
      loud_limit  = loud_limit << LEVEL_FRAC;
      model_loud  = (model_level > loud_limit);
      level_int   = model_level >> LEVEL_FRAC;
      report.is_loud      = model_loud;
      report.loud_changed = (model_loud != prior_loud);
      report.level        = level_int[afld_pkg::LEVEL_OUT_W-1:0];
      expected_reports.push_back(report);
   endfunction

   // Random sample within +/- 2^span, with the two rails mixed in.
   function automatic logic signed [15:0] draw_sample(int unsigned span);
      logic signed [15:0] raw;
      raw = 16'($urandom);
      case ($urandom_range(0, 15))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         default: return raw >>> (15 - span);
      endcase
   endfunction

   // Offer one sample word, hold it until taken, then predict.
   task automatic send_sample(input logic signed [15:0] value, input logic last,
                              input logic muted);
      int unsigned gap;
      gap = sample_gaps_on ? $urandom_range(0, 3) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_sample_value  <= value;
      req_last_in_frame <= last;
      req_frame_muted   <= muted;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_frame_level(value, last, muted);
   endtask

   // Only the closing word's mute flag counts; randomize it on the others.
   task automatic send_frame(input int unsigned length, input logic muted_end,
                             input int unsigned span);
      int unsigned n;
      for (n = 1; n < length; n++)
         send_sample(draw_sample(span), 1'b0, 1'($urandom_range(0, 1)));
      send_sample(draw_sample(span), 1'b1, muted_end);
   endtask

   task automatic write_register(input afld_pkg::csr_index_type index,
                                 input logic [afld_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         afld_pkg::CSR_THRESHOLD_LEVEL: model_threshold = value[afld_pkg::THRESHOLD_W-1:0];
         afld_pkg::CSR_SMOOTHING_GAIN:  model_gain      = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Stop offering words, wait out every report, then let the block go idle.
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_levels(input logic [afld_pkg::THRESHOLD_W-1:0] threshold,
                             input logic [afld_pkg::GAIN_W-1:0] gain);
      drain_results();
      write_register(afld_pkg::CSR_THRESHOLD_LEVEL, {1'b0, threshold});
      write_register(afld_pkg::CSR_SMOOTHING_GAIN, gain);
   endtask

   // Run on the reset register values; rails, +/-1 and zero samples.
   task automatic test_reset_defaults();
      send_sample(16'sh7FFF, 1'b0, 1'b1);
      send_sample(16'sh8000, 1'b1, 1'b0);
      send_sample(16'sh0000, 1'b1, 1'b0);
      send_sample(-16'sd1, 1'b0, 1'b0);
      send_sample(16'sd1, 1'b1, 1'b0);
   endtask

   // Muted closing word clears the level and drops the frame's samples.
   task automatic test_muted_frames();
      send_sample(16'sh7FFF, 1'b0, 1'b0);
      send_sample(16'sd100, 1'b0, 1'b0);
      send_sample(16'sh8000, 1'b1, 1'b1);
      // Mute set on a middle word only: the frame still counts.
      send_sample(16'sh8000, 1'b0, 1'b1);
      send_sample(16'sh7FFF, 1'b1, 1'b0);
   endtask

   // Register extremes: gain above one, zero gain, tiny gain, threshold rails.
   task automatic test_gain_and_threshold();
      set_levels(16'd0, 17'h1FFFF);
      send_sample(16'sd100, 1'b1, 1'b0);
      // Unmapped indexes must leave both registers alone.
      drain_results();
      write_register(CSR_UNMAPPED_2, 17'h1FFFF);
      write_register(CSR_UNMAPPED_3, 17'h00000);
      send_sample(16'sh8000, 1'b1, 1'b0);
      set_levels(16'hFFFF, 17'd0);
      send_sample(16'sh0000, 1'b1, 1'b0);
      set_levels(16'd32767, 17'd1);
      send_sample(16'sh0000, 1'b1, 1'b0);
      // Level equal to the threshold is not loud.
      set_levels(16'd32768, afld_pkg::GAIN_ONE);
      send_sample(16'sh8000, 1'b1, 1'b0);
   endtask

   // Frames at and past FRAME_MAX words; run without gaps to keep it short.
   task automatic test_long_frames();
      int unsigned n;
      set_levels(16'd32768, afld_pkg::GAIN_ONE);
      sample_gaps_on   = 1'b0;
      result_stalls_on = 1'b0;
      // Exactly FRAME_MAX rail words: the sum reaches its ceiling.
      for (n = 1; n < FRAME_MAX; n++)
         send_sample(16'sh8000, 1'b0, 1'b0);
      send_sample(16'sh8000, 1'b1, 1'b0);
      // Past FRAME_MAX: the tail, closing word included, adds nothing.
      for (n = 0; n < FRAME_MAX + 3; n++)
         send_sample(draw_sample(15), 1'b0, 1'(n));
      send_sample(16'sh7FFF, 1'b1, 1'b0);
      sample_gaps_on   = 1'b1;
      result_stalls_on = 1'b1;
   endtask

   // Hold rsp_ready low for a long stretch while frames keep coming, so the
   // output slot fills and the block pushes back on req_ready.
   task automatic test_result_backpressure();
      int unsigned n;
      set_levels(16'd2000, 17'd30000);
      sample_gaps_on = 1'b0;
      @(posedge clock);
      rsp_hold_cycles = 400;
      for (n = 0; n < 12; n++)
         send_frame($urandom_range(1, 3), 1'($urandom_range(0, 5) == 0), 15);
      sample_gaps_on = 1'b1;
   endtask

   // Random frames in phases, each with its own register setting and idling.
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned sel;
      int unsigned frame_len;
      int unsigned random_samples;
      logic [afld_pkg::THRESHOLD_W-1:0] threshold;
      logic [afld_pkg::GAIN_W-1:0]      gain;
      random_samples = 0;
      for (phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 5))
            0:       threshold = 16'd0;
            1:       threshold = 16'hFFFF;
            2:       threshold = 16'd32768;
            5:       threshold = 16'($urandom);
            default: threshold = 16'($urandom_range(0, 4000));
         endcase
         case ($urandom_range(0, 6))
            0:       gain = 17'd0;
            1:       gain = afld_pkg::GAIN_ONE;
            2:       gain = 17'h1FFFF;
            3:       gain = 17'($urandom);
            default: gain = 17'($urandom_range(1, 40000));
         endcase
         set_levels(threshold, gain);
         // Phase 2 runs flat out; phases 4 and 5 idle on one side only.
         sample_gaps_on   = (phase != 2) && (phase != 5);
         result_stalls_on = (phase != 2) && (phase != 4);
         while (random_samples < (phase + 1) * RANDOM_SAMPLES / 6) begin
            sel = $urandom_range(0, 99);
            if (sel < 80)
               frame_len = $urandom_range(1, 8);
            else if (sel < 98)
               frame_len = $urandom_range(9, 40);
            else
               frame_len = $urandom_range(41, 200);
            send_frame(frame_len, 1'($urandom_range(0, 5) == 0), $urandom_range(0, 15));
            random_samples += frame_len;
         end
      end
      sample_gaps_on   = 1'b1;
      result_stalls_on = 1'b1;
   endtask

   // Drive rsp_ready: a long hold when asked, else the per-word pause.
   initial begin : result_ready_driver
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold_cycles--;
         end else if (result_pause != 0) begin
            rsp_ready <= 1'b0;
            result_pause--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each taken report word with the oldest expectation.
   always @(posedge clock) begin : report_checker
      level_report_type want;
      level_report_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got = {rsp_is_loud, rsp_loud_changed, rsp_level};
         if (expected_reports.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: report with none expected: loud %b changed %b level %0d",
                        $realtime, got.is_loud, got.loud_changed, got.level);
         end else begin
            want = expected_reports.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: want loud %b chg %b lvl %0d, got loud %b chg %b lvl %0d",
                           $realtime, want.is_loud, want.loud_changed, want.level,
                           got.is_loud, got.loud_changed, got.level);
            end
         end
         result_pause = result_stalls_on ? $urandom_range(0, 3) : 0;
      end
   end

   initial begin : test_sequence
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_sample_value  = '0;
      req_last_in_frame = 1'b0;
      req_frame_muted   = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = afld_pkg::CSR_THRESHOLD_LEVEL;
      csr_data          = '0;
      model_threshold   = afld_pkg::THRESHOLD_RESET;
      model_gain        = afld_pkg::GAIN_RESET;
      model_sum         = 0;
      model_count       = 0;
      model_level       = 0;
      model_loud        = 1'b0;
      mismatch_count    = 0;
      result_pause      = 0;
      rsp_hold_cycles   = 0;
      sample_gaps_on    = 1'b1;
      result_stalls_on  = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_muted_frames();
      test_gain_and_threshold();
      test_long_frames();
      test_result_backpressure();
      test_random_traffic();
      drain_results();

      if (mismatch_count == 0 && expected_reports.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
src/afld_pkg.sv
src/afld_core.sv
src/audio_frame_level_detector.sv
tb/tb_audio_frame_level_detector.sv
